### rtl/core/bankers_safety_check_macros.svh
// Assertion macros for the banker's algorithm safety check.
// Used by the datapath and the top level; needs i_clk and i_rst_n in scope.
`ifndef BANKERS_SAFETY_CHECK_MACROS_SVH
`define BANKERS_SAFETY_CHECK_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BSC_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bsc_pkg.sv
// Shared types, constants and the microprogram for the safety check.
// No dependencies; used by every module of the block but bsc_ram.
package bsc_pkg;

    // Sizing of the stores.
    localparam int MAX_PROCS = 16;
    localparam int MAX_RES   = 8;
    localparam int VAL_BITS  = 16;

    localparam int PROC_BITS = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int RES_BITS  = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
    localparam int CNT_BITS  = $clog2(MAX_PROCS + 1);
    localparam int MCNT_BITS = $clog2(MAX_RES + 1);
    localparam int CELLS     = MAX_PROCS * MAX_RES;
    localparam int ADDR_BITS = $clog2(CELLS);
    localparam int NEED_BITS = VAL_BITS + 1;
    localparam int CELL_BITS = VAL_BITS + NEED_BITS;
    localparam int WORK_BITS = VAL_BITS + $clog2(MAX_PROCS) + 1;

    // Fixed port widths.
    localparam int CMD_BITS       = 2;
    localparam int PROC_F_BITS    = 4;
    localparam int RES_F_BITS     = 3;
    localparam int VAL_F_BITS     = 16;
    localparam int PID_F_BITS     = 4;
    localparam int NPROC_CFG_BITS = 5;
    localparam int NRES_CFG_BITS  = 4;
    localparam int PADDR_BITS     = 3;
    localparam int PDATA_BITS     = 32;

    localparam logic [NPROC_CFG_BITS-1:0] NUM_PROCS_RST = 5'd16;
    localparam logic [NRES_CFG_BITS-1:0]  NUM_RES_RST   = 4'd8;

    // Register indexes (paddr bit 2).
    localparam logic REG_NUM_PROCS = 1'b0;
    localparam logic REG_NUM_RES   = 1'b1;

    // Commands.
    localparam logic [CMD_BITS-1:0] CMD_LOAD_CELL  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_LOAD_AVAIL = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_RUN        = 2'd2;

    // Microprogram steps.
    localparam int STEP_BITS = 4;
    localparam logic [STEP_BITS-1:0] ST_IDLE        = 4'd0;
    localparam logic [STEP_BITS-1:0] ST_INIT        = 4'd1;
    localparam logic [STEP_BITS-1:0] ST_PROC_START  = 4'd2;
    localparam logic [STEP_BITS-1:0] ST_CHK_RD      = 4'd3;
    localparam logic [STEP_BITS-1:0] ST_CHK_CMP     = 4'd4;
    localparam logic [STEP_BITS-1:0] ST_CHK_END     = 4'd5;
    localparam logic [STEP_BITS-1:0] ST_GR_RD       = 4'd6;
    localparam logic [STEP_BITS-1:0] ST_GR_ADD      = 4'd7;
    localparam logic [STEP_BITS-1:0] ST_GRANT       = 4'd8;
    localparam logic [STEP_BITS-1:0] ST_EMIT        = 4'd9;
    localparam logic [STEP_BITS-1:0] ST_NEXT_PROC   = 4'd10;
    localparam logic [STEP_BITS-1:0] ST_P_INC       = 4'd11;
    localparam logic [STEP_BITS-1:0] ST_PASS_END    = 4'd12;
    localparam logic [STEP_BITS-1:0] ST_NEW_PASS    = 4'd13;
    localparam logic [STEP_BITS-1:0] ST_EMIT_UNSAFE = 4'd14;

    // Jump conditions.
    localparam int COND_BITS = 4;
    localparam logic [COND_BITS-1:0] COND_SEQ        = 4'd0;
    localparam logic [COND_BITS-1:0] COND_ALWAYS     = 4'd1;
    localparam logic [COND_BITS-1:0] COND_NOT_START  = 4'd2;
    localparam logic [COND_BITS-1:0] COND_DONE       = 4'd3;
    localparam logic [COND_BITS-1:0] COND_R_MORE     = 4'd4;
    localparam logic [COND_BITS-1:0] COND_NOT_OK     = 4'd5;
    localparam logic [COND_BITS-1:0] COND_GRANT_LAST = 4'd6;
    localparam logic [COND_BITS-1:0] COND_P_LAST     = 4'd7;
    localparam logic [COND_BITS-1:0] COND_NOT_FOUND  = 4'd8;

    typedef struct packed {
        logic init_run;
        logic proc_start;
        logic chk_cmp;
        logic r_clr;
        logic add_work;
        logic grant;
        logic emit_safe;
        logic emit_unsafe;
        logic p_inc;
        logic new_pass;
    } t_ops;

    typedef struct packed {
        logic [COND_BITS-1:0] cond;
        logic [STEP_BITS-1:0] target;
        logic                 wait_out;
        t_ops                 ops;
    } t_uword;

    typedef struct packed {
        logic start;
        logic done_p;
        logic ok;
        logic r_more;
        logic p_last;
        logic granted_last;
        logic found;
        logic slot_free;
    } t_flags;

    typedef struct packed {
        logic                 wr_cell;
        logic                 wr_avail;
        logic [PROC_BITS-1:0] proc;
        logic [RES_BITS-1:0]  res;
        logic [VAL_BITS-1:0]  alloc_v;
        logic [VAL_BITS-1:0]  max_v;
        logic [VAL_BITS-1:0]  avail_v;
    } t_load;

    function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [PROC_BITS-1:0] p,
                                                       input logic [RES_BITS-1:0] r);
        return ADDR_BITS'(p) * ADDR_BITS'(MAX_RES) + ADDR_BITS'(r);
    endfunction

    // The control store: one word per step.
    function automatic t_uword urom(input logic [STEP_BITS-1:0] step);
        t_uword w;
        w = '0;
        unique case (step)
            ST_IDLE: begin
                w.cond = COND_NOT_START;
                w.target = ST_IDLE;
            end
            ST_INIT: begin
                w.ops.init_run = 1'b1;
            end
            ST_PROC_START: begin
                w.ops.proc_start = 1'b1;
                w.cond = COND_DONE;
                w.target = ST_NEXT_PROC;
            end
            ST_CHK_RD: begin
                w.cond = COND_SEQ;
            end
            ST_CHK_CMP: begin
                w.ops.chk_cmp = 1'b1;
                w.cond = COND_R_MORE;
                w.target = ST_CHK_RD;
            end
            ST_CHK_END: begin
                w.ops.r_clr = 1'b1;
                w.cond = COND_NOT_OK;
                w.target = ST_NEXT_PROC;
            end
            ST_GR_RD: begin
                w.cond = COND_SEQ;
            end
            ST_GR_ADD: begin
                w.ops.add_work = 1'b1;
                w.cond = COND_R_MORE;
                w.target = ST_GR_RD;
            end
            ST_GRANT: begin
                w.ops.grant = 1'b1;
            end
            ST_EMIT: begin
                w.wait_out = 1'b1;
                w.ops.emit_safe = 1'b1;
                w.cond = COND_GRANT_LAST;
                w.target = ST_IDLE;
            end
            ST_NEXT_PROC: begin
                w.cond = COND_P_LAST;
                w.target = ST_PASS_END;
            end
            ST_P_INC: begin
                w.ops.p_inc = 1'b1;
                w.cond = COND_ALWAYS;
                w.target = ST_PROC_START;
            end
            ST_PASS_END: begin
                w.cond = COND_NOT_FOUND;
                w.target = ST_EMIT_UNSAFE;
            end
            ST_NEW_PASS: begin
                w.ops.new_pass = 1'b1;
                w.cond = COND_ALWAYS;
                w.target = ST_PROC_START;
            end
            ST_EMIT_UNSAFE: begin
                w.wait_out = 1'b1;
                w.ops.emit_unsafe = 1'b1;
                w.cond = COND_ALWAYS;
                w.target = ST_IDLE;
            end
            default: begin
                w.cond = COND_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

### rtl/core/bsc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/bsc_useq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on bsc_pkg.
module bsc_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bsc_pkg::t_flags i_flags,
    output bsc_pkg::t_ops   o_ops,
    output logic            o_busy
);

    logic [bsc_pkg::STEP_BITS-1:0] r_upc;
    logic [bsc_pkg::STEP_BITS-1:0] n_upc;
    bsc_pkg::t_uword               w_cw;
    logic                          w_hold;
    logic                          w_take;

    always_comb begin
        w_cw = bsc_pkg::urom(r_upc);
        // An emit step holds until the output register can take a word.
        w_hold = w_cw.wait_out && !i_flags.slot_free;
        unique case (w_cw.cond)
            bsc_pkg::COND_SEQ:        w_take = 1'b0;
            bsc_pkg::COND_ALWAYS:     w_take = 1'b1;
            bsc_pkg::COND_NOT_START:  w_take = !i_flags.start;
            bsc_pkg::COND_DONE:       w_take = i_flags.done_p;
            bsc_pkg::COND_R_MORE:     w_take = i_flags.r_more;
            bsc_pkg::COND_NOT_OK:     w_take = !i_flags.ok;
            bsc_pkg::COND_GRANT_LAST: w_take = i_flags.granted_last;
            bsc_pkg::COND_P_LAST:     w_take = i_flags.p_last;
            bsc_pkg::COND_NOT_FOUND:  w_take = !i_flags.found;
            default:                  w_take = 1'b1;
        endcase
        if (w_hold) begin
            n_upc = r_upc;
        end else if (w_take) begin
            n_upc = w_cw.target;
        end else begin
            n_upc = r_upc + 1'b1;
        end
        o_ops = w_hold ? '0 : w_cw.ops;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= bsc_pkg::ST_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_busy = (r_upc != bsc_pkg::ST_IDLE);

endmodule

### rtl/core/bsc_dpath.sv
// Datapath: cell memory, available counts, working accumulator, finish marks,
// process and resource counters, and the output register. Depends on bsc_pkg,
// bsc_ram and the assertion macros.
`include "bankers_safety_check_macros.svh"

module bsc_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bsc_pkg::t_ops                  i_ops,
    input  bsc_pkg::t_load                 i_load,
    input  logic                           i_start,
    input  logic [bsc_pkg::CNT_BITS-1:0]   i_n_eff,
    input  logic [bsc_pkg::MCNT_BITS-1:0]  i_m_eff,
    input  logic                           i_out_stall,
    output bsc_pkg::t_flags                o_flags,
    output logic                           o_out_valid,
    output logic                           o_safe,
    output logic [bsc_pkg::PID_F_BITS-1:0] o_proc_id,
    output logic                           o_last
);

    logic [bsc_pkg::PROC_BITS-1:0]                     r_p;
    logic [bsc_pkg::RES_BITS-1:0]                      r_r;
    logic                                              r_ok;
    logic                                              r_found;
    logic [bsc_pkg::CNT_BITS-1:0]                      r_granted;
    logic [bsc_pkg::MAX_PROCS-1:0]                     r_done;
    logic [bsc_pkg::MAX_RES-1:0][bsc_pkg::WORK_BITS-1:0] r_work;
    logic [bsc_pkg::VAL_BITS-1:0]                      r_avail [bsc_pkg::MAX_RES];
    logic                                              r_out_valid;
    logic                                              r_out_safe;
    logic [bsc_pkg::PID_F_BITS-1:0]                    r_out_pid;
    logic                                              r_out_last;

    logic [bsc_pkg::CELL_BITS-1:0] w_wr_data;
    logic [bsc_pkg::CELL_BITS-1:0] w_rd_data;
    logic [bsc_pkg::NEED_BITS-1:0] w_need_wr;
    logic [bsc_pkg::VAL_BITS-1:0]  w_rd_alloc;
    logic [bsc_pkg::NEED_BITS-1:0] w_rd_need;
    logic [bsc_pkg::WORK_BITS-1:0] w_need_mag;
    logic                          w_over;
    logic                          w_slot_free;

    // A cell word holds the allocation above the signed need.
    assign w_need_wr = {1'b0, i_load.max_v} - {1'b0, i_load.alloc_v};
    assign w_wr_data = {i_load.alloc_v, w_need_wr};

    bsc_ram #(
        .WIDTH (bsc_pkg::CELL_BITS),
        .DEPTH (bsc_pkg::CELLS)
    ) u_cells (
        .i_clk     (i_clk),
        .i_wr_en   (i_load.wr_cell),
        .i_wr_addr (bsc_pkg::cell_addr(i_load.proc, i_load.res)),
        .i_wr_data (w_wr_data),
        .i_rd_addr (bsc_pkg::cell_addr(r_p, r_r)),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_alloc = w_rd_data[bsc_pkg::CELL_BITS-1 -: bsc_pkg::VAL_BITS];
    assign w_rd_need  = w_rd_data[bsc_pkg::NEED_BITS-1:0];
    assign w_need_mag = bsc_pkg::WORK_BITS'(w_rd_need[bsc_pkg::NEED_BITS-2:0]);
    // A negative or zero need always fits.
    assign w_over = !w_rd_need[bsc_pkg::NEED_BITS-1] && (w_rd_need != '0)
                    && (w_need_mag > r_work[r_r]);
    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_flags.start        = i_start;
        o_flags.done_p       = r_done[r_p];
        o_flags.ok           = r_ok;
        o_flags.r_more       = (bsc_pkg::MCNT_BITS'(r_r)
                                != (i_m_eff - bsc_pkg::MCNT_BITS'(1)));
        o_flags.p_last       = (bsc_pkg::CNT_BITS'(r_p)
                                == (i_n_eff - bsc_pkg::CNT_BITS'(1)));
        o_flags.granted_last = (r_granted == i_n_eff);
        o_flags.found        = r_found;
        o_flags.slot_free    = w_slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_load.wr_avail) begin
            r_avail[i_load.res] <= i_load.avail_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p         <= '0;
            r_r         <= '0;
            r_ok        <= 1'b0;
            r_found     <= 1'b0;
            r_granted   <= '0;
            r_done      <= '0;
            r_work      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ops.init_run) begin
                r_done    <= '0;
                r_granted <= '0;
                r_p       <= '0;
                r_found   <= 1'b0;
                for (int i = 0; i < bsc_pkg::MAX_RES; i++) begin
                    r_work[i] <= bsc_pkg::WORK_BITS'(r_avail[i]);
                end
            end
            if (i_ops.proc_start) begin
                r_r  <= '0;
                r_ok <= 1'b1;
            end
            if (i_ops.chk_cmp) begin
                if (w_over) begin
                    r_ok <= 1'b0;
                end
                r_r <= r_r + 1'b1;
            end
            if (i_ops.r_clr) begin
                r_r <= '0;
            end
            if (i_ops.add_work) begin
                r_work[r_r] <= r_work[r_r] + bsc_pkg::WORK_BITS'(w_rd_alloc);
                r_r         <= r_r + 1'b1;
            end
            if (i_ops.grant) begin
                r_done[r_p] <= 1'b1;
                r_granted   <= r_granted + bsc_pkg::CNT_BITS'(1);
                r_found     <= 1'b1;
            end
            if (i_ops.p_inc) begin
                r_p <= r_p + 1'b1;
            end
            if (i_ops.new_pass) begin
                r_p     <= '0;
                r_found <= 1'b0;
            end
            if (i_ops.emit_safe || i_ops.emit_unsafe) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ops.emit_safe) begin
            r_out_safe <= 1'b1;
            r_out_pid  <= bsc_pkg::PID_F_BITS'(r_p);
            r_out_last <= o_flags.granted_last;
        end else if (i_ops.emit_unsafe) begin
            r_out_safe <= 1'b0;
            r_out_pid  <= '0;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_safe      = r_out_safe;
    assign o_proc_id   = r_out_pid;
    assign o_last      = r_out_last;

    `BSC_ASSERT(a_grant_unfinished, i_ops.grant, !r_done[r_p], "grant of a finished process")
    `BSC_ASSERT(a_emit_slot_free, i_ops.emit_safe || i_ops.emit_unsafe, w_slot_free,
                "result word overwritten while waiting")
    `BSC_ASSERT_NEXT(a_work_quiet, !(i_ops.init_run || i_ops.add_work), $stable(r_work),
                     "working counts changed outside init or grant")

endmodule

### rtl/core/bankers_safety_check.sv
// Banker's algorithm safety check. Load words write one process/resource cell
// (allocation and maximum claim, stored as allocation and signed need) or one
// available count. A run word restarts the check: it clears the finish marks,
// copies the available counts into a working accumulator and scans the
// processes in passes until every process has been granted or a whole pass
// grants nothing. Each grant gives one result word (safe = 1, proc_id of the
// process, last = 1 on the final grant); a stalled pass gives one word
// safe = 0, proc_id = 0, last = 1. The input is stalled from the run word's
// acceptance until its final result word has been loaded into the output
// register. A run is stepped by a microcoded sequencer over a single-read-port
// cell memory: each unfinished process has its needs read and compared with
// the working counts one resource type at a time, a fitting one then has its
// allocations read and added in the same way before its result word waits
// for a free output register, and a finished process is skipped. Configuration
// registers: num_procs at byte address 0 and num_res at byte address 4; a
// value of 0 acts as 1 and values above the store size saturate, while a read
// returns the raw register field rather than the effective count. They may be
// written only while the block is idle.
`include "bankers_safety_check_macros.svh"

module bankers_safety_check (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bsc_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [bsc_pkg::PDATA_BITS-1:0]   pwdata,
    output logic [bsc_pkg::PDATA_BITS-1:0]   prdata,
    output logic                             pready,
    // Input channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [bsc_pkg::CMD_BITS-1:0]     i_cmd,
    input  logic [bsc_pkg::PROC_F_BITS-1:0]  i_proc,
    input  logic [bsc_pkg::RES_F_BITS-1:0]   i_res,
    input  logic [bsc_pkg::VAL_F_BITS-1:0]   i_alloc_value,
    input  logic [bsc_pkg::VAL_F_BITS-1:0]   i_max_value,
    input  logic [bsc_pkg::VAL_F_BITS-1:0]   i_avail_value,
    // Output channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_safe,
    output logic [bsc_pkg::PID_F_BITS-1:0]   o_proc_id,
    output logic                             o_last
);

    logic [bsc_pkg::NPROC_CFG_BITS-1:0] r_num_procs;
    logic [bsc_pkg::NRES_CFG_BITS-1:0]  r_num_res;
    logic [bsc_pkg::CNT_BITS-1:0]       w_n_eff;
    logic [bsc_pkg::MCNT_BITS-1:0]      w_m_eff;
    logic                               w_cfg_wr;
    logic                               w_busy;
    logic                               w_in_accept;
    logic                               w_start;
    bsc_pkg::t_load                     w_load;
    bsc_pkg::t_ops                      w_ops;
    bsc_pkg::t_flags                    w_flags;

    // Configuration registers. Only paddr bit 2 selects the register.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_procs <= bsc_pkg::NUM_PROCS_RST;
            r_num_res   <= bsc_pkg::NUM_RES_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == bsc_pkg::REG_NUM_PROCS) begin
                r_num_procs <= pwdata[bsc_pkg::NPROC_CFG_BITS-1:0];
            end else begin
                r_num_res <= pwdata[bsc_pkg::NRES_CFG_BITS-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == bsc_pkg::REG_NUM_RES) ? bsc_pkg::PDATA_BITS'(r_num_res)
                                                       : bsc_pkg::PDATA_BITS'(r_num_procs);

    // Effective counts: zero acts as one, large values saturate to the store size.
    always_comb begin
        if (r_num_procs == '0) begin
            w_n_eff = bsc_pkg::CNT_BITS'(1);
        end else if (32'(r_num_procs) > 32'(bsc_pkg::MAX_PROCS)) begin
            w_n_eff = bsc_pkg::CNT_BITS'(bsc_pkg::MAX_PROCS);
        end else begin
            w_n_eff = bsc_pkg::CNT_BITS'(r_num_procs);
        end
        if (r_num_res == '0) begin
            w_m_eff = bsc_pkg::MCNT_BITS'(1);
        end else if (32'(r_num_res) > 32'(bsc_pkg::MAX_RES)) begin
            w_m_eff = bsc_pkg::MCNT_BITS'(bsc_pkg::MAX_RES);
        end else begin
            w_m_eff = bsc_pkg::MCNT_BITS'(r_num_res);
        end
    end

    // Input words are taken whenever the sequencer is idle. Loads go straight
    // to the stores; out-of-range indices and the unused command are dropped.
    assign o_stall     = w_busy;
    assign w_in_accept = i_valid && !o_stall;
    assign w_start     = w_in_accept && (i_cmd == bsc_pkg::CMD_RUN);

    always_comb begin
        w_load.wr_cell  = w_in_accept && (i_cmd == bsc_pkg::CMD_LOAD_CELL)
                          && (32'(i_proc) < 32'(bsc_pkg::MAX_PROCS))
                          && (32'(i_res) < 32'(bsc_pkg::MAX_RES));
        w_load.wr_avail = w_in_accept && (i_cmd == bsc_pkg::CMD_LOAD_AVAIL)
                          && (32'(i_res) < 32'(bsc_pkg::MAX_RES));
        w_load.proc     = bsc_pkg::PROC_BITS'(i_proc);
        w_load.res      = bsc_pkg::RES_BITS'(i_res);
        w_load.alloc_v  = bsc_pkg::VAL_BITS'(i_alloc_value);
        w_load.max_v    = bsc_pkg::VAL_BITS'(i_max_value);
        w_load.avail_v  = bsc_pkg::VAL_BITS'(i_avail_value);
    end

    bsc_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ops   (w_ops),
        .o_busy  (w_busy)
    );

    bsc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ops       (w_ops),
        .i_load      (w_load),
        .i_start     (w_start),
        .i_n_eff     (w_n_eff),
        .i_m_eff     (w_m_eff),
        .i_out_stall (i_stall),
        .o_flags     (w_flags),
        .o_out_valid (o_valid),
        .o_safe      (o_safe),
        .o_proc_id   (o_proc_id),
        .o_last      (o_last)
    );

    // A new result word only appears while a run is in progress.
    `BSC_ASSERT(a_result_in_run, o_valid && !$past(o_valid), $past(w_busy),
                "result word outside a run")
    // An accepted run word always starts the sequencer.
    `BSC_ASSERT(a_run_starts, $past(i_rst_n) && $past(w_start), w_busy,
                "run word accepted but sequencer idle")

endmodule

### test/bankers_safety_check_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the banker's algorithm safety check.
// Needs bsc_pkg and bankers_safety_check; predicts every run's grant words and checks them.

module bankers_safety_check_tb;

    // The spare command code has no name in the package; the block must ignore it.
    localparam logic [bsc_pkg::CMD_BITS-1:0] CMD_SPARE = 2'd3;

    // Cycles to let pass after the last result word before a register write, so
    // that any trailing load has landed in the stores.
    localparam int SETTLE_CYCLES = 10;
    // Cycles to watch for stray words once everything expected has arrived.
    localparam int TAIL_CYCLES = 50;

    typedef struct packed {
        logic                           safe;
        logic [bsc_pkg::PID_F_BITS-1:0] proc_id;
        logic                           last;
    } t_grant_word;

    // Value ranges used to steer runs: tiny values give mostly safe systems,
    // full-range values mostly unsafe ones.
    typedef enum int {SCALE_TINY, SCALE_BYTE, SCALE_FULL} t_value_scale;

    // ------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [bsc_pkg::PADDR_BITS-1:0]  paddr = '0;
    logic [bsc_pkg::PDATA_BITS-1:0]  pwdata = '0;
    logic [bsc_pkg::PDATA_BITS-1:0]  prdata;
    logic                            pready;
    logic                            i_valid = 1'b0;
    logic                            o_stall;
    logic [bsc_pkg::CMD_BITS-1:0]    i_cmd = '0;
    logic [bsc_pkg::PROC_F_BITS-1:0] i_proc = '0;
    logic [bsc_pkg::RES_F_BITS-1:0]  i_res = '0;
    logic [bsc_pkg::VAL_F_BITS-1:0]  i_alloc_value = '0;
    logic [bsc_pkg::VAL_F_BITS-1:0]  i_max_value = '0;
    logic [bsc_pkg::VAL_F_BITS-1:0]  i_avail_value = '0;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic                            o_safe;
    logic [bsc_pkg::PID_F_BITS-1:0]  o_proc_id;
    logic                            o_last;

    bankers_safety_check DUT (.*);

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the block's state, kept in step with accepted words
    // ------------------------------------------------------------------
    logic [bsc_pkg::VAL_BITS-1:0]         alloc_mem [bsc_pkg::CELLS];
    logic signed [bsc_pkg::NEED_BITS-1:0] need_mem  [bsc_pkg::CELLS];
    logic [bsc_pkg::VAL_BITS-1:0]         avail_mem [bsc_pkg::MAX_RES];
    bit                                   cell_loaded [bsc_pkg::CELLS];
    logic [bsc_pkg::NPROC_CFG_BITS-1:0]   cfg_procs = bsc_pkg::NUM_PROCS_RST;
    logic [bsc_pkg::NRES_CFG_BITS-1:0]    cfg_res = bsc_pkg::NUM_RES_RST;

    // Result words still owed by the block, oldest first.
    t_grant_word grants_due [$];
    int          error_count = 0;

    // Traffic controls shared by the test tasks and the stall driver.
    bit offering = 1'b0;    // i_valid is currently held high by the sender
    bit send_gaps = 1'b1;   // sender inserts idle bursts
    bit recv_stalls = 1'b1; // receiver inserts stall bursts
    int hold_left = 0;      // long receiver hold-off, counted down per cycle

    // The register value 0 means one, values past the store size saturate.
    function automatic int procs_in_use();
        if (cfg_procs == 0) return 1;
        if (cfg_procs > bsc_pkg::MAX_PROCS) return bsc_pkg::MAX_PROCS;
        return int'(cfg_procs);
    endfunction

    function automatic int res_in_use();
        if (cfg_res == 0) return 1;
        if (cfg_res > bsc_pkg::MAX_RES) return bsc_pkg::MAX_RES;
        return int'(cfg_res);
    endfunction

    // Works out the grant words of one run from the shadow state. Processes
    // are scanned in order in repeated passes; a process is granted as soon
    // as every positive need fits the working counts, and its allocation is
    // returned to the pool right away, so later processes of the same pass
    // already see it. A pass that grants nothing closes the run as unsafe.
    function automatic void predict_safety_run();
        logic [bsc_pkg::WORK_BITS-1:0] work [bsc_pkg::MAX_RES];
        bit                            finished [bsc_pkg::MAX_PROCS];
        int                            n, m, p, r, granted, need;
        bit                            found, fits;
        t_grant_word                   w;
        n = procs_in_use();
        m = res_in_use();
        granted = 0;
        for (r = 0; r < bsc_pkg::MAX_RES; r++) begin
            work[r] = bsc_pkg::WORK_BITS'(avail_mem[r]);
        end
        for (p = 0; p < bsc_pkg::MAX_PROCS; p++) finished[p] = 1'b0;
        while (granted < n) begin
            found = 1'b0;
            for (p = 0; p < n; p++) begin
                if (!finished[p]) begin
                    fits = 1'b1;
                    for (r = 0; r < m; r++) begin
                        // A negative need (claim below allocation) always fits.
                        need = int'(need_mem[p * bsc_pkg::MAX_RES + r]);
                        if (need > 0 && need > int'(work[r])) fits = 1'b0;
                    end
                    if (fits) begin
                        for (r = 0; r < m; r++) begin
                            work[r] = work[r]
                                      + bsc_pkg::WORK_BITS'(alloc_mem[p * bsc_pkg::MAX_RES + r]);
                        end
                        finished[p] = 1'b1;
                        granted++;
                        found = 1'b1;
                        w.safe = 1'b1;
                        w.proc_id = bsc_pkg::PID_F_BITS'(p);
                        w.last = (granted == n);
                        grants_due.push_back(w);
                    end
                end
            end
            if (!found) begin
                w.safe = 1'b0;
                w.proc_id = '0;
                w.last = 1'b1;
                grants_due.push_back(w);
                break;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    task automatic release_input();
        if (offering) begin
            i_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // Offers one word, waits until the block takes it, then updates the
    // shadow state. Valid is left high on return so that the next word can
    // follow back to back; whoever stops sending drops it.
    task automatic send_word(input logic [bsc_pkg::CMD_BITS-1:0]    cmd,
                             input logic [bsc_pkg::PROC_F_BITS-1:0] proc,
                             input logic [bsc_pkg::RES_F_BITS-1:0]  res,
                             input logic [bsc_pkg::VAL_F_BITS-1:0]  alloc_v,
                             input logic [bsc_pkg::VAL_F_BITS-1:0]  max_v,
                             input logic [bsc_pkg::VAL_F_BITS-1:0]  avail_v);
        int idx;
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            release_input();
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_proc <= proc;
        i_res <= res;
        i_alloc_value <= alloc_v;
        i_max_value <= max_v;
        i_avail_value <= avail_v;
        offering = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        idx = int'(proc) * bsc_pkg::MAX_RES + int'(res);
        case (cmd)
            bsc_pkg::CMD_LOAD_CELL: begin
                alloc_mem[idx] = alloc_v;
                need_mem[idx] = {1'b0, max_v} - {1'b0, alloc_v};
                cell_loaded[idx] = 1'b1;
            end
            bsc_pkg::CMD_LOAD_AVAIL: begin
                avail_mem[res] = avail_v;
            end
            bsc_pkg::CMD_RUN: begin
                predict_safety_run();
            end
            default: begin
            end
        endcase
    endtask

    function automatic logic [bsc_pkg::VAL_F_BITS-1:0] any_value();
        return bsc_pkg::VAL_F_BITS'($urandom_range(0, 65535));
    endfunction

    // Unused fields of each command carry random values so that they are
    // seen to have no effect.
    task automatic load_cell(input int p, input int r,
                             input logic [bsc_pkg::VAL_F_BITS-1:0] alloc_v,
                             input logic [bsc_pkg::VAL_F_BITS-1:0] max_v);
        send_word(bsc_pkg::CMD_LOAD_CELL, bsc_pkg::PROC_F_BITS'(p), bsc_pkg::RES_F_BITS'(r),
                  alloc_v, max_v, any_value());
    endtask

    task automatic load_avail(input int r, input logic [bsc_pkg::VAL_F_BITS-1:0] avail_v);
        send_word(bsc_pkg::CMD_LOAD_AVAIL, bsc_pkg::PROC_F_BITS'($urandom_range(0, 15)),
                  bsc_pkg::RES_F_BITS'(r), any_value(), any_value(), avail_v);
    endtask

    task automatic run_check();
        send_word(bsc_pkg::CMD_RUN, bsc_pkg::PROC_F_BITS'($urandom_range(0, 15)),
                  bsc_pkg::RES_F_BITS'($urandom_range(0, 7)),
                  any_value(), any_value(), any_value());
    endtask

    // Stops offering and waits until every owed result word has come back.
    task automatic wait_drained();
        release_input();
        do @(posedge i_clk); while (grants_due.size() != 0);
    endtask

    // Register writes go in only while the block is idle: all results in,
    // then a wait of SETTLE_CYCLES for the last load to settle.
    task automatic write_register(input logic reg_sel, input int value);
        logic [bsc_pkg::PDATA_BITS-1:0] data;
        data = $urandom();
        if (reg_sel == bsc_pkg::REG_NUM_PROCS) begin
            data[bsc_pkg::NPROC_CFG_BITS-1:0] = bsc_pkg::NPROC_CFG_BITS'(value);
        end else begin
            data[bsc_pkg::NRES_CFG_BITS-1:0] = bsc_pkg::NRES_CFG_BITS'(value);
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= bsc_pkg::PADDR_BITS'({reg_sel, 2'b00});
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == bsc_pkg::REG_NUM_PROCS) cfg_procs = data[bsc_pkg::NPROC_CFG_BITS-1:0];
        else cfg_res = data[bsc_pkg::NRES_CFG_BITS-1:0];
    endtask

    function automatic logic [bsc_pkg::VAL_F_BITS-1:0] scaled_value(input t_value_scale scale);
        case (scale)
            SCALE_TINY: return bsc_pkg::VAL_F_BITS'($urandom_range(0, 7));
            SCALE_BYTE: return bsc_pkg::VAL_F_BITS'($urandom_range(0, 255));
            default:    return bsc_pkg::VAL_F_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    // A claim at or above the allocation, clipped to the field range.
    function automatic logic [bsc_pkg::VAL_F_BITS-1:0] claim_above(
        input logic [bsc_pkg::VAL_F_BITS-1:0] alloc_v, input t_value_scale scale);
        int sum;
        sum = int'(alloc_v) + int'(scaled_value(scale));
        return (sum > 65535) ? 16'hFFFF : bsc_pkg::VAL_F_BITS'(sum);
    endfunction

    // Loads every cell in use that was never written, so no run reads one.
    task automatic fill_gaps(input t_value_scale scale);
        int p, r;
        logic [bsc_pkg::VAL_F_BITS-1:0] a;
        for (p = 0; p < procs_in_use(); p++) begin
            for (r = 0; r < res_in_use(); r++) begin
                if (!cell_loaded[p * bsc_pkg::MAX_RES + r]) begin
                    a = scaled_value(scale);
                    load_cell(p, r, a, claim_above(a, scale));
                end
            end
        end
    endtask

    // One well-formed burst of loads followed by a run, with some noise:
    // ignored commands, loads outside the cells in use, a run left out, or
    // a run repeated on unchanged state.
    task automatic random_sequence(input t_value_scale scale);
        int n, m, kind;
        logic [bsc_pkg::VAL_F_BITS-1:0] a;
        n = procs_in_use();
        m = res_in_use();
        repeat ($urandom_range(1, 6)) begin
            kind = $urandom_range(0, 19);
            if (kind < 15) begin
                a = scaled_value(scale);
                load_cell($urandom_range(0, n - 1), $urandom_range(0, m - 1), a,
                          ($urandom_range(0, 2) != 0) ? claim_above(a, scale)
                                                      : scaled_value(scale));
            end else if (kind < 18) begin
                load_avail($urandom_range(0, bsc_pkg::MAX_RES - 1), scaled_value(scale));
            end else if (kind == 18) begin
                send_word(CMD_SPARE, bsc_pkg::PROC_F_BITS'($urandom_range(0, 15)),
                          bsc_pkg::RES_F_BITS'($urandom_range(0, 7)),
                          any_value(), any_value(), any_value());
            end else begin
                load_cell($urandom_range(0, 15), $urandom_range(0, 7), any_value(), any_value());
            end
        end
        fill_gaps(scale);
        if ($urandom_range(0, 9) != 0) run_check();
        if ($urandom_range(0, 7) == 0) run_check();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every available count is written once here, with the field extremes,
    // so that the copy into the working counts never reads an unwritten one.
    task automatic test_available_extremes();
        int r;
        load_avail(0, 16'hFFFF);
        load_avail(1, 16'h0000);
        load_avail(2, 16'hAAAA);
        load_avail(3, 16'h5555);
        for (r = 4; r < bsc_pkg::MAX_RES; r++) load_avail(r, scaled_value(SCALE_TINY));
    endtask

    // Register value 0 acts as one process and one resource type.
    task automatic test_single_process();
        write_register(bsc_pkg::REG_NUM_PROCS, 0);
        write_register(bsc_pkg::REG_NUM_RES, 0);
        // The spare command with every bit set must leave no trace.
        send_word(CMD_SPARE, 4'd15, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // Claim below allocation: the need is negative and always fits.
        load_cell(0, 0, 16'hFFFF, 16'h0000);
        run_check();
        // Need exactly equal to the available count is granted.
        load_cell(0, 0, 16'h0000, 16'hFFFF);
        run_check();
        // One unit short: unsafe without any grant.
        load_avail(0, 16'hFFFE);
        run_check();
    endtask

    // One grant, then a pass that grants nothing: unsafe after a grant.
    task automatic test_partial_unsafe();
        write_register(bsc_pkg::REG_NUM_PROCS, 2);
        write_register(bsc_pkg::REG_NUM_RES, 1);
        load_avail(0, 16'h0000);
        load_cell(0, 0, 16'h0000, 16'hFFFF);
        load_cell(1, 0, 16'h0001, 16'h0001);
        run_check();
    endtask

    // All sixteen processes on one resource with full allocations, so the
    // working count climbs far past the field width; process 0 only fits
    // on the second pass.
    task automatic test_wide_accumulate();
        int p;
        write_register(bsc_pkg::REG_NUM_PROCS, 16);
        write_register(bsc_pkg::REG_NUM_RES, 1);
        load_avail(0, 16'h0001);
        load_cell(0, 0, 16'h0000, 16'hFFFF);
        for (p = 1; p < bsc_pkg::MAX_PROCS; p++) load_cell(p, 0, 16'hFFFF, 16'hFFFF);
        run_check();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering words, so the block backs up and stalls its input. Then the
    // sender pauses until every owed word is back.
    task automatic test_output_backpressure();
        write_register(bsc_pkg::REG_NUM_PROCS, 8);
        write_register(bsc_pkg::REG_NUM_RES, 2);
        fill_gaps(SCALE_TINY);
        hold_left = 300;
        run_check();
        repeat (3) load_cell($urandom_range(0, 7), $urandom_range(0, 1),
                             bsc_pkg::VAL_F_BITS'($urandom_range(0, 7)),
                             bsc_pkg::VAL_F_BITS'($urandom_range(0, 15)));
        run_check();
        wait_drained();
    endtask

    // Random words over a series of register settings, the extremes and the
    // out-of-range values among them. The last phase runs with no idling.
    task automatic test_random_phases();
        int procs_raw [8] = '{3, 5, 31, 2, 8, 0, 16, 4};
        int res_raw   [8] = '{2, 4, 1, 15, 3, 8, 0, 2};
        int ph, pick, seqs;
        t_value_scale scale;
        for (ph = 0; ph < 8; ph++) begin
            write_register(bsc_pkg::REG_NUM_PROCS, procs_raw[ph]);
            write_register(bsc_pkg::REG_NUM_RES, res_raw[ph]);
            send_gaps = (ph != 3) && (ph != 7);
            recv_stalls = (ph != 4) && (ph != 7);
            // Full-size stores make runs slow; keep those phases short.
            seqs = (procs_in_use() * res_in_use() > 64) ? 2 : $urandom_range(2, 3);
            repeat (seqs) begin
                pick = $urandom_range(0, 3);
                scale = (pick < 2) ? SCALE_TINY : (pick == 2) ? SCALE_BYTE : SCALE_FULL;
                random_sequence(scale);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver stall driver: random bursts, plus the long hold-off that a
    // test can request through hold_left.
    // ------------------------------------------------------------------
    initial begin : stall_driver
        int burst;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_stall <= 1'b1;
            end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(0, 17);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result word against the oldest one owed.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_checker
        t_grant_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (grants_due.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual safe=%0b proc_id=%0d last=%0b",
                         $time, o_safe, o_proc_id, o_last);
                error_count++;
            end else begin
                want = grants_due.pop_front();
                if (o_safe !== want.safe) begin
                    $display("%0t: safe: expected %0b, actual %0b", $time, want.safe, o_safe);
                    error_count++;
                end
                if (o_proc_id !== want.proc_id) begin
                    $display("%0t: proc_id: expected %0d, actual %0d",
                             $time, want.proc_id, o_proc_id);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last: expected %0b, actual %0b", $time, want.last, o_last);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_available_extremes();
        test_single_process();
        test_partial_unsafe();
        test_wide_accumulate();
        test_output_backpressure();
        test_random_phases();
        wait_drained();
        // Any word arriving now has no expectation and is flagged by the checker.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog. A correct run stays well below this time limit.
    initial begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### bankers_safety_check.f
+incdir+rtl/core
rtl/core/bsc_pkg.sv
rtl/core/bsc_ram.sv
rtl/core/bsc_useq.sv
rtl/core/bsc_dpath.sv
rtl/core/bankers_safety_check.sv
test/bankers_safety_check_tb.sv
